@@ sv/assert_macros.svh @@
// Assertion macros for the checker file of the matrix inverse block.
// No dependencies; included by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define M3I_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is checked during reset as well.
`define M3I_ASSERT_RST(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/m3i_pkg.sv @@
// Package for the 3x3 matrix inverse: widths, minor index table and stage types.
// No dependencies; used by every module and interface file of the block.
`default_nettype none

package m3i_pkg;

   // Entry width and the default, smallest and largest number of fraction bits.
   localparam int DATA_W        = 32;
   localparam int FRAC_BITS_DEF = 16;
   localparam int FRAC_BITS_MIN = 8;
   localparam int FRAC_BITS_MAX = 30;

   // Matrix size and divider lanes (nine entries plus the reciprocal check).
   localparam int NUM_ENT    = 9;
   localparam int NUM_LANE   = NUM_ENT + 1;
   localparam int RECIP_LANE = NUM_ENT;

   // Exact intermediate widths.
   localparam int PROD_W = 2 * DATA_W;      // one 32x32 product
   localparam int COF_W  = PROD_W + 1;      // difference of two products
   localparam int CMAG_W = COF_W - 1;       // magnitude of a cofactor
   localparam int DET_W  = COF_W + DATA_W;  // signed determinant
   localparam int DMAG_W = DET_W - 2;       // magnitude of the determinant
   localparam int REM_W  = DMAG_W + 1;      // doubled divisor and partial remainder
   localparam int QUO_W  = DATA_W;          // quotient bits produced
   // Doubled numerator plus divisor; wide enough for the largest fraction setting.
   localparam int NUM_W  = 128;

   // Operand indexes of each cofactor: cof = m[a] * m[b] - m[c] * m[d].
   localparam int MINOR_IDX [NUM_ENT][4] = '{
      '{4, 8, 5, 7}, '{5, 6, 3, 8}, '{3, 7, 4, 6},
      '{2, 7, 1, 8}, '{0, 8, 2, 6}, '{1, 6, 0, 7},
      '{1, 5, 2, 4}, '{2, 3, 0, 5}, '{0, 4, 1, 3}
   };

   typedef logic [NUM_ENT-1:0][DATA_W-1:0] mat_type;
   typedef logic [NUM_ENT-1:0][COF_W-1:0]  cof_type;

   // Cofactor stage to determinant stage.
   typedef struct packed {
      mat_type m;
      cof_type cof;
   } cof_out_type;

   // Determinant stage to divider setup.
   typedef struct packed {
      cof_type           cof;
      logic [DET_W-1:0]  det;
   } det_out_type;

   // Divider setup to divider pipeline.
   typedef struct packed {
      logic [REM_W-1:0]                 dmag2;
      logic [NUM_LANE-1:0][NUM_W-1:0]   num;
      logic [NUM_LANE-1:0]              neg;
      logic                             zero;
   } div_in_type;

   // Divider pipeline to output stage.
   typedef struct packed {
      logic [NUM_LANE-1:0][QUO_W-1:0]   quo;
      logic [NUM_LANE-1:0]              neg;
      logic [NUM_LANE-1:0]              ovf;
      logic                             zero;
   } div_out_type;

endpackage

`default_nettype wire

@@ sv/m3i_if.sv @@
// Request and response channel interfaces of the matrix inverse block.
// Depends on m3i_pkg.
`default_nettype none

interface m3i_req_if;
   import m3i_pkg::*;

   logic valid;
   logic ready;
   logic signed [DATA_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

   modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                   input ready);
   modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                   output ready);
   modport monitor (input valid, ready, m00, m01, m02, m10, m11, m12, m20, m21, m22);
endinterface

interface m3i_rsp_if;
   import m3i_pkg::*;

   logic valid;
   logic ready;
   logic signed [DATA_W-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
   logic failed;

   modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, failed,
                   input ready);
   modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, failed,
                   output ready);
   modport monitor (input valid, ready, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                    failed);
endinterface

`default_nettype wire

@@ sv/m3i_cofactor.sv @@
// Two pipeline stages: eighteen 32x32 products, then the nine signed cofactors.
// Depends on m3i_pkg.
`default_nettype none

module m3i_cofactor (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  m3i_pkg::mat_type      in_mat,
   output logic                  out_valid,
   output m3i_pkg::cof_out_type  out_data
);
   import m3i_pkg::*;

   logic [2*NUM_ENT-1:0][PROD_W-1:0] prod_in, prod_ff;
   mat_type     mat_ff;
   logic        valid1_ff, valid2_ff;
   cof_out_type data_in, data_ff;

   // Stage one: both products of every 2x2 minor.
   always_comb begin
      logic signed [DATA_W-1:0] a, b, c, d;
      logic signed [PROD_W-1:0] pab, pcd;
      for (int k = 0; k < NUM_ENT; k++) begin
         a   = in_mat[MINOR_IDX[k][0]];
         b   = in_mat[MINOR_IDX[k][1]];
         c   = in_mat[MINOR_IDX[k][2]];
         d   = in_mat[MINOR_IDX[k][3]];
         pab = a * b;
         pcd = c * d;
         prod_in[2*k]   = pab;
         prod_in[2*k+1] = pcd;
      end
   end

   // Stage two: exact cofactors, one bit wider than a product.
   always_comb begin
      logic signed [COF_W-1:0] x, y;
      data_in.m = mat_ff;
      for (int k = 0; k < NUM_ENT; k++) begin
         x = $signed(prod_ff[2*k]);
         y = $signed(prod_ff[2*k+1]);
         data_in.cof[k] = x - y;
      end
   end

   // Valid bits travel with the data and hold while the pipeline is stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else if (en) begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         mat_ff  <= in_mat;
         data_ff <= data_in;
      end
   end

   assign out_valid = valid2_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

@@ sv/m3i_det.sv @@
// Two pipeline stages: first-row cofactor products split in halves, then the determinant.
// Depends on m3i_pkg.
`default_nettype none

module m3i_det (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  m3i_pkg::cof_out_type  in_data,
   output logic                  out_valid,
   output m3i_pkg::det_out_type  out_data
);
   import m3i_pkg::*;

   // A 65-bit cofactor is cut into a low unsigned part and a high signed part.
   localparam int SPLIT = COF_W - DATA_W;
   localparam int PPL_W = SPLIT + 1 + DATA_W;
   localparam int PPH_W = 2 * DATA_W;

   logic [2:0][PPL_W-1:0] ppl_in, ppl_ff;
   logic [2:0][PPH_W-1:0] pph_in, pph_ff;
   cof_type     cof_ff;
   logic        valid1_ff, valid2_ff;
   det_out_type data_in, data_ff;

   // Stage one: partial products of each first-row cofactor and its matrix entry.
   always_comb begin
      logic signed [SPLIT:0]        lo_op;
      logic signed [DATA_W-1:0]     hi_op, mv;
      logic signed [PPL_W-1:0]      plo;
      logic signed [PPH_W-1:0]      phi;
      for (int j = 0; j < 3; j++) begin
         lo_op     = {1'b0, in_data.cof[j][SPLIT-1:0]};
         hi_op     = in_data.cof[j][COF_W-1:SPLIT];
         mv        = in_data.m[j];
         plo       = lo_op * mv;
         phi       = hi_op * mv;
         ppl_in[j] = plo;
         pph_in[j] = phi;
      end
   end

   // Stage two: sum of the six partial products.
   always_comb begin
      logic signed [DET_W-1:0] acc, th, tl;
      acc = '0;
      for (int j = 0; j < 3; j++) begin
         th  = $signed(pph_ff[j]);
         tl  = $signed(ppl_ff[j]);
         acc = acc + (th <<< SPLIT) + tl;
      end
      data_in.det = acc;
      data_in.cof = cof_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else if (en) begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ppl_ff  <= ppl_in;
         pph_ff  <= pph_in;
         cof_ff  <= in_data.cof;
         data_ff <= data_in;
      end
   end

   assign out_valid = valid2_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

@@ sv/m3i_prep.sv @@
// Two pipeline stages that set up the divisions: magnitudes and signs, then the
// rounding numerators 2|n| + |d| and the doubled divisor. Depends on m3i_pkg.
`default_nettype none

module m3i_prep #(
   parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  m3i_pkg::det_out_type  in_data,
   output logic                  out_valid,
   output m3i_pkg::div_in_type   out_data
);
   import m3i_pkg::*;

   localparam int ENT_SHIFT   = 2 * FRAC_BITS + 1;
   localparam int RECIP_SHIFT = 4 * FRAC_BITS + 1;

   logic [NUM_ENT-1:0][CMAG_W-1:0] cmag_in, cmag_ff;
   logic [NUM_ENT-1:0]             cneg_in, cneg_ff;
   logic [DMAG_W-1:0]              dmag_in, dmag_ff;
   logic                           dneg_ff, zero_ff;
   logic                           valid1_ff, valid2_ff;
   div_in_type                     data_in, data_ff;

   // Stage one: absolute values and signs of the cofactors and the determinant.
   always_comb begin
      logic [COF_W-1:0] cabs;
      logic [DET_W-1:0] dabs;
      for (int k = 0; k < NUM_ENT; k++) begin
         cneg_in[k] = in_data.cof[k][COF_W-1];
         cabs       = cneg_in[k] ? (~in_data.cof[k] + 1'b1) : in_data.cof[k];
         cmag_in[k] = cabs[CMAG_W-1:0];
      end
      dabs    = in_data.det[DET_W-1] ? (~in_data.det + 1'b1) : in_data.det;
      dmag_in = dabs[DMAG_W-1:0];
   end

   // Stage two: numerators in result order; entry (i, j) divides cofactor (j, i).
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            data_in.num[i*3+j] = (NUM_W'(cmag_ff[j*3+i]) << ENT_SHIFT) + NUM_W'(dmag_ff);
            data_in.neg[i*3+j] = cneg_ff[j*3+i] ^ dneg_ff;
         end
      end
      data_in.num[RECIP_LANE] = (NUM_W'(1) << RECIP_SHIFT) + NUM_W'(dmag_ff);
      data_in.neg[RECIP_LANE] = dneg_ff;
      data_in.dmag2           = {dmag_ff, 1'b0};
      data_in.zero            = zero_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else if (en) begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cmag_ff <= cmag_in;
         cneg_ff <= cneg_in;
         dmag_ff <= dmag_in;
         dneg_ff <= in_data.det[DET_W-1];
         zero_ff <= (in_data.det == '0);
         data_ff <= data_in;
      end
   end

   assign out_valid = valid2_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

@@ sv/m3i_div.sv @@
// Pipelined restoring divider, ten lanes sharing one divisor: an overflow check stage
// and then one quotient bit per stage. Depends on m3i_pkg.
`default_nettype none

module m3i_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  m3i_pkg::div_in_type   in_data,
   output logic                  out_valid,
   output m3i_pkg::div_out_type  out_data
);
   import m3i_pkg::*;

   localparam int NUM_STAGE = QUO_W + 1;
   localparam int HI_W      = NUM_W - QUO_W;

   logic [NUM_STAGE-1:0]                           valid_ff;
   logic [NUM_STAGE-1:0][NUM_LANE-1:0][REM_W-1:0]  rem_in, rem_ff;
   logic [NUM_STAGE-1:0][NUM_LANE-1:0][QUO_W-1:0]  sh_in, sh_ff;
   logic [NUM_STAGE-1:0][REM_W-1:0]                dv_in, dv_ff;
   logic [NUM_STAGE-1:0][NUM_LANE-1:0]             neg_in, neg_ff, ovf_in, ovf_ff;
   logic [NUM_STAGE-1:0]                           zero_in, zero_ff;

   // The first stage loads the upper numerator bits as the partial remainder; the
   // quotient would not fit in 32 bits if they already reach the divisor. Each later
   // stage shifts in one numerator bit, compares and subtracts, and shifts the
   // quotient bit into the freed place of the numerator register.
   always_comb begin
      logic [REM_W:0] t, diff;
      logic           ge;
      for (int s = 0; s < NUM_STAGE; s++) begin
         if (s == 0) begin
            for (int l = 0; l < NUM_LANE; l++) begin
               rem_in[s][l] = REM_W'(in_data.num[l][NUM_W-1:QUO_W]);
               sh_in[s][l]  = in_data.num[l][QUO_W-1:0];
               ovf_in[s][l] = REM_W'(in_data.num[l][NUM_W-1:NUM_W-HI_W]) >= in_data.dmag2;
            end
            dv_in[s]   = in_data.dmag2;
            neg_in[s]  = in_data.neg;
            zero_in[s] = in_data.zero;
         end else begin
            for (int l = 0; l < NUM_LANE; l++) begin
               t            = {rem_ff[s-1][l], sh_ff[s-1][l][QUO_W-1]};
               diff         = t - {1'b0, dv_ff[s-1]};
               ge           = t >= {1'b0, dv_ff[s-1]};
               rem_in[s][l] = ge ? diff[REM_W-1:0] : t[REM_W-1:0];
               sh_in[s][l]  = {sh_ff[s-1][l][QUO_W-2:0], ge};
            end
            dv_in[s]   = dv_ff[s-1];
            neg_in[s]  = neg_ff[s-1];
            ovf_in[s]  = ovf_ff[s-1];
            zero_in[s] = zero_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[NUM_STAGE-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         sh_ff   <= sh_in;
         dv_ff   <= dv_in;
         neg_ff  <= neg_in;
         ovf_ff  <= ovf_in;
         zero_ff <= zero_in;
      end
   end

   assign out_valid     = valid_ff[NUM_STAGE-1];
   assign out_data.quo  = sh_ff[NUM_STAGE-1];
   assign out_data.neg  = neg_ff[NUM_STAGE-1];
   assign out_data.ovf  = ovf_ff[NUM_STAGE-1];
   assign out_data.zero = zero_ff[NUM_STAGE-1];

endmodule

`default_nettype wire

@@ sv/matrix3x3_inverse.sv @@
// Top level of the 3x3 fixed-point matrix inverse (adjugate over determinant).
// Depends on m3i_pkg, m3i_if, m3i_cofactor, m3i_det, m3i_prep and m3i_div.
//
//   Channel   Direction   Handshake            Carries
//   req_ch    in          valid / ready        m00 .. m22, signed Q(32-F).F
//   rsp_ch    out         valid / ready        r00 .. r22, failed
//
// One matrix enters per cycle while the pipeline advances; its response leaves the last
// of 40 register stages, 33 of them in the shared-divisor divider.
// Synchronous reset clears the valid bits of every stage; data registers are not reset.
// The whole pipeline advances together whenever the output register is empty or taken;
// a stalled response holds and nothing inside is lost or repeated.
`default_nettype none

module matrix3x3_inverse #(
   parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   m3i_req_if.sink    req_ch,
   m3i_rsp_if.source  rsp_ch
);
   import m3i_pkg::*;

   logic          en;
   mat_type       in_mat;
   logic          cof_valid, det_valid, prep_valid, div_valid;
   cof_out_type   cof_data;
   det_out_type   det_data;
   div_in_type    prep_data;
   div_out_type   div_data;

   logic [NUM_ENT-1:0][DATA_W-1:0] res_in, res_ff;
   logic                           fail_in, fail_ff;
   logic                           rsp_valid_ff;

   // Global advance: the output register is free or is being transferred.
   assign en           = ~rsp_valid_ff | rsp_ch.ready;
   assign req_ch.ready = en & ~reset;

   assign in_mat = {req_ch.m22, req_ch.m21, req_ch.m20,
                    req_ch.m12, req_ch.m11, req_ch.m10,
                    req_ch.m02, req_ch.m01, req_ch.m00};

   m3i_cofactor u_cofactor (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_ch.valid & req_ch.ready),
      .in_mat    (in_mat),
      .out_valid (cof_valid),
      .out_data  (cof_data)
   );

   m3i_det u_det (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (cof_valid),
      .in_data   (cof_data),
      .out_valid (det_valid),
      .out_data  (det_data)
   );

   m3i_prep #(
      .FRAC_BITS (FRAC_BITS)
   ) u_prep (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (det_valid),
      .in_data   (det_data),
      .out_valid (prep_valid),
      .out_data  (prep_data)
   );

   m3i_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (prep_valid),
      .in_data   (prep_data),
      .out_valid (div_valid),
      .out_data  (div_data)
   );

   // Output stage: range check of every rounded quotient, sign, and the zero fill
   // when the matrix is singular or anything is out of range.
   always_comb begin
      logic [QUO_W-1:0] q;
      logic             bad;
      fail_in = div_data.zero | (|div_data.ovf);
      for (int l = 0; l < NUM_LANE; l++) begin
         q   = div_data.quo[l];
         bad = div_data.neg[l] ? (q[QUO_W-1] & (|q[QUO_W-2:0])) : q[QUO_W-1];
         fail_in = fail_in | bad;
      end
      for (int l = 0; l < NUM_ENT; l++) begin
         q         = div_data.quo[l];
         res_in[l] = div_data.neg[l] ? (~q + 1'b1) : q;
      end
      if (fail_in) begin
         res_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff  <= res_in;
         fail_ff <= fail_in;
      end
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.r00    = res_ff[0];
   assign rsp_ch.r01    = res_ff[1];
   assign rsp_ch.r02    = res_ff[2];
   assign rsp_ch.r10    = res_ff[3];
   assign rsp_ch.r11    = res_ff[4];
   assign rsp_ch.r12    = res_ff[5];
   assign rsp_ch.r20    = res_ff[6];
   assign rsp_ch.r21    = res_ff[7];
   assign rsp_ch.r22    = res_ff[8];
   assign rsp_ch.failed = fail_ff;

endmodule

`default_nettype wire

@@ sv/m3i_checker.sv @@
// Port-level checks of the matrix inverse, bound to the top level.
// Depends on m3i_pkg, matrix3x3_inverse and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module m3i_props (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              req_ready,
   input  logic                                              rsp_valid,
   input  logic                                              rsp_ready,
   input  logic                                              rsp_failed,
   input  logic [m3i_pkg::NUM_ENT-1:0][m3i_pkg::DATA_W-1:0]  rsp_res
);

   logic all_zero;

   // A failed result carries nine zero entries.
   assign all_zero = (rsp_res == '0);

   `M3I_ASSERT(a_fail_zero, clock, reset, rsp_valid && rsp_failed |-> all_zero, "failed result has nonzero entries")
   `M3I_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_res) && $stable(rsp_failed), "stalled response changed")
   `M3I_ASSERT_RST(a_reset_empty, clock, reset |=> !rsp_valid, "response valid right after reset")
   `M3I_ASSERT(a_accept_free, clock, reset, !rsp_valid |-> req_ready, "request refused with empty output")

endmodule

bind matrix3x3_inverse m3i_props u_m3i_props (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_failed (rsp_ch.failed),
   .rsp_res    ({rsp_ch.r22, rsp_ch.r21, rsp_ch.r20,
                 rsp_ch.r12, rsp_ch.r11, rsp_ch.r10,
                 rsp_ch.r02, rsp_ch.r01, rsp_ch.r00})
);

`default_nettype wire
